/* sv/ssof_pkg.sv */
// ----------------------------------------------------------------------------
// ssof_pkg
// Shared types and constants of the sweep smallest-object finder: the item
// sideband that travels down the width pipeline, register indexes and the
// fixed-point constants of the chord-width series.
// ----------------------------------------------------------------------------
`default_nettype none

package ssof_pkg;

  // Configuration register indexes
  localparam logic REG_NEAR_THRESHOLD  = 1'b0;
  localparam logic REG_MATCH_TOLERANCE = 1'b1;

  // Register reset values
  localparam logic [7:0] NEAR_THRESHOLD_RST  = 8'd50;
  localparam logic [7:0] MATCH_TOLERANCE_RST = 8'd3;

  // Marker for "no object" and the empty best width
  localparam logic [7:0] NO_OBJECT = 8'd255;

  // Angle fold point in degrees
  localparam logic [7:0] HALF_TURN = 8'd180;
  localparam logic [8:0] FULL_TURN = 9'd360;

  // Radians per half degree, Q30
  localparam logic [31:0] RAD_PER_HALF_DEG = 32'd9370165;

  // One in Q30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Nested sine series: divisors from the innermost term outward
  localparam int NUM_TERMS = 5;
  localparam logic [6:0] DIVISOR [NUM_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  // floor(2^32 / divisor); the quotient estimate is low by at most one
  localparam logic [29:0] RECIP [NUM_TERMS] = '{
    30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72),
    30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20),
    30'((64'd1 << 32) / 64'd6)
  };

  // Sideband of one sample beat on its way to the best-object compare
  typedef struct packed {
    logic       valid;
    logic       close;
    logic       last;
    logic [7:0] mid_angle;
    logic [7:0] ping_cm;
  } side_t;

endpackage

`default_nettype wire

/* sv/ssof_chord.sv */
// ----------------------------------------------------------------------------
// ssof_chord
// Chord width pipeline: folds the angle span, converts it to radians, runs the
// five nested sine series terms (multiply, reciprocal divide, correct) and
// scales by twice the ping distance, saturating to 8 bits. All stages move
// together on en; the sideband travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ssof_chord (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire ssof_pkg::side_t side_in,
  input  wire logic [7:0]     h_raw_in,
  output ssof_pkg::side_t     side_out,
  output logic [7:0]          width_out
);

  localparam int NT = ssof_pkg::NUM_TERMS;

  typedef struct packed {
    ssof_pkg::side_t side;
    logic [30:0]     x;
    logic [31:0]     x2;
  } carry_t;

  // Front stages
  ssof_pkg::side_t a_side;
  ssof_pkg::side_t b_side;
  logic [7:0]      a_h;
  logic [30:0]     b_x;
  carry_t          c_carry;

  logic [7:0]  h_fold;
  logic [31:0] x_full;
  logic [61:0] xx_prod;

  // Series term stages
  carry_t      term_c_in [NT];
  logic [30:0] term_t_in [NT];
  carry_t      ta_c [NT];
  carry_t      tb_c [NT];
  carry_t      tc_c [NT];
  logic [31:0] ta_y [NT];
  logic [31:0] tb_y [NT];
  logic [29:0] tb_q [NT];
  logic [30:0] tc_t [NT];

  // Tail stages
  ssof_pkg::side_t s_side;
  logic [30:0]     s_val;
  logic [61:0]     s_prod;
  logic [38:0]     w_prod;
  logic [7:0]      w_sat;

  // Fold the span so the half angle stays within a quarter turn
  always_comb begin
    if (h_raw_in > ssof_pkg::HALF_TURN) begin
      h_fold = 8'(ssof_pkg::FULL_TURN - {1'b0, h_raw_in});
    end else begin
      h_fold = h_raw_in;
    end
  end

  assign x_full  = 32'(a_h) * ssof_pkg::RAD_PER_HALF_DEG;
  assign xx_prod = 62'(b_x) * 62'(b_x);

  // Front pipeline: fold, radians, square
  always_ff @(posedge clk) begin
    if (rst) begin
      a_side        <= '0;
      b_side        <= '0;
      c_carry.side  <= '0;
    end else if (en) begin
      a_side        <= side_in;
      b_side        <= a_side;
      c_carry.side  <= b_side;
      c_carry.x     <= b_x;
      c_carry.x2    <= xx_prod[61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_h        <= h_fold;
      b_x        <= x_full[30:0];
    end
  end

  // Nested series: t = 1 - ((x2 * t) >> 30) / divisor, starting from t = 1
  for (genvar k = 0; k < NT; k++) begin : g_term
    logic [61:0] a_prod;
    logic [61:0] b_prod;
    logic [31:0] c_qd;
    logic [31:0] c_rem;
    logic        c_fix;

    if (k == 0) begin : g_first
      assign term_c_in[k] = c_carry;
      assign term_t_in[k] = ssof_pkg::Q30_ONE;
    end else begin : g_next
      assign term_c_in[k] = tc_c[k-1];
      assign term_t_in[k] = tc_t[k-1];
    end

    assign a_prod = 62'(term_c_in[k].x2) * 62'(term_t_in[k]);
    assign b_prod = 62'(ta_y[k]) * 62'(ssof_pkg::RECIP[k]);
    assign c_qd   = 32'(tb_q[k]) * 32'(ssof_pkg::DIVISOR[k]);
    assign c_rem  = tb_y[k] - c_qd;
    assign c_fix  = (c_rem >= 32'(ssof_pkg::DIVISOR[k]));

    // Advance the sideband and operands of this term
    always_ff @(posedge clk) begin
      if (rst) begin
        ta_c[k] <= '0;
        tb_c[k] <= '0;
        tc_c[k] <= '0;
      end else if (en) begin
        ta_c[k] <= term_c_in[k];
        tb_c[k] <= ta_c[k];
        tc_c[k] <= tb_c[k];
      end
    end

    // Multiply, estimate the quotient, correct it and subtract from one
    always_ff @(posedge clk) begin
      if (en) begin
        ta_y[k] <= a_prod[61:30];
        tb_y[k] <= ta_y[k];
        tb_q[k] <= b_prod[61:32];
        tc_t[k] <= ssof_pkg::Q30_ONE - 31'(tb_q[k]) - 31'(c_fix);
      end
    end
  end

  assign s_prod = 62'(tc_c[NT-1].x) * 62'(tc_t[NT-1]);
  assign w_prod = 39'(s_side.ping_cm) * 39'(s_val);

  // Saturate 2*d*s >> 30 to eight bits
  always_comb begin
    if (w_prod[38:37] != 2'b00) begin
      w_sat = ssof_pkg::NO_OBJECT;
    end else begin
      w_sat = w_prod[36:29];
    end
  end

  // Tail pipeline: sine, width
  always_ff @(posedge clk) begin
    if (rst) begin
      s_side   <= '0;
      side_out <= '0;
    end else if (en) begin
      s_side   <= tc_c[NT-1].side;
      side_out <= s_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_val     <= s_prod[60:30];
      width_out <= w_sat;
    end
  end

endmodule

`default_nettype wire

/* sv/sweep_smallest_object_finder.sv */
// ----------------------------------------------------------------------------
// sweep_smallest_object_finder
// Finds the narrowest object in a sweep of range samples and reports its mid
// angle on the final sample.
// ----------------------------------------------------------------------------
// One sample beat is accepted every clock cycle while in_ready is high.
// Each beat writes its ping distance into a dual-port store and, when it
// closes an object, reads the store at the object's midpoint index in the
// same cycle. The chord width then runs through a 20-stage arithmetic
// pipeline (five nested sine terms of three stages each plus fold, radians,
// square, sine and scale stages), and the narrowest width is kept at its
// end, where the result for a sweep is registered as the beat carrying last
// arrives. A spare register behind the result register catches one more
// result while the receiver stalls, so input beats keep flowing and in_ready
// never depends on out_ready in the same cycle; the pipeline holds only when
// that spare is full and a further end-of-sweep beat reaches its end.
// Sample indexes start at zero at reset and after every last beat.
`default_nettype none

module sweep_smallest_object_finder #(
  parameter int MAX_SAMPLES = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Sample channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] angle,
  input  wire logic [7:0] ir_distance,
  input  wire logic [7:0] ping_distance,
  input  wire logic       last,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      smallest_angle,
  // Configuration
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int IW = $clog2(MAX_SAMPLES);

  // Configuration registers
  logic [7:0] near_threshold;
  logic [7:0] match_tolerance;

  // Sweep tracking state
  logic [7:0]    prev_ir;
  logic [7:0]    prev_angle;
  logic          have_prev;
  logic          in_object;
  logic [7:0]    open_start_angle;
  logic [IW-1:0] open_start_index;
  logic [IW-1:0] sample_index;
  logic [7:0]    best_width;
  logic [7:0]    best_angle;

  // Ping store
  logic [7:0] ping_mem [MAX_SAMPLES];
  logic [7:0] ping_rd;

  // Front-end decode
  logic          accept;
  logic          adv;
  logic [IW-1:0] prev_idx;
  logic [IW-1:0] next_idx;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid_addr;
  logic          near;
  logic [7:0]    ir_diff;
  logic          do_open;
  logic          do_close;
  logic [8:0]    ang_sum;
  logic [7:0]    h_raw;

  // First stage
  ssof_pkg::side_t s1_side;
  logic [7:0]      s1_h_raw;
  logic            s1_fwd;
  logic [7:0]      s1_fwd_ping;

  // Width pipeline
  ssof_pkg::side_t chord_side_in;
  ssof_pkg::side_t fin_side;
  logic [7:0]      fin_width;

  // Best-object update
  logic       better;
  logic [7:0] best_width_next;
  logic [7:0] best_angle_next;

  // Result output and spare
  logic       result_due;
  logic       held_valid;
  logic [7:0] held_angle;

  assign accept     = in_valid && in_ready;
  assign adv        = !(held_valid && fin_side.valid && fin_side.last);
  assign in_ready   = adv;
  assign result_due = adv && fin_side.valid && fin_side.last;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold  <= ssof_pkg::NEAR_THRESHOLD_RST;
      match_tolerance <= ssof_pkg::MATCH_TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssof_pkg::REG_NEAR_THRESHOLD:  near_threshold  <= cfg_data;
        ssof_pkg::REG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Index arithmetic with wrap at the store depth
  assign prev_idx = (sample_index == '0) ? IW'(MAX_SAMPLES - 1) : sample_index - IW'(1);
  assign next_idx = (sample_index == IW'(MAX_SAMPLES - 1)) ? '0 : sample_index + IW'(1);
  assign mid_sum  = {1'b0, open_start_index} + {1'b0, prev_idx};
  assign mid_addr = mid_sum[IW:1];

  // Compare the new sample with the previous one
  assign near     = prev_ir < near_threshold;
  assign ir_diff  = (prev_ir >= ir_distance) ? prev_ir - ir_distance : ir_distance - prev_ir;
  assign do_open  = have_prev && !in_object && near && (ir_diff < match_tolerance);
  assign do_close = have_prev && in_object && near && (ir_distance >= near_threshold);

  assign ang_sum = {1'b0, open_start_angle} + {1'b0, prev_angle};
  assign h_raw   = (prev_angle >= open_start_angle) ? prev_angle - open_start_angle
                                                    : open_start_angle - prev_angle;

  // Track objects across the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev    <= 1'b0;
      in_object    <= 1'b0;
      sample_index <= '0;
    end else if (accept) begin
      if (last) begin
        have_prev    <= 1'b0;
        in_object    <= 1'b0;
        sample_index <= '0;
      end else begin
        have_prev    <= 1'b1;
        sample_index <= next_idx;
        if (do_open) begin
          in_object <= 1'b1;
        end else if (do_close) begin
          in_object <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ir          <= '0;
      prev_angle       <= '0;
      open_start_angle <= '0;
      open_start_index <= '0;
    end else if (accept) begin
      prev_ir    <= ir_distance;
      prev_angle <= angle;
      if (do_open) begin
        open_start_angle <= prev_angle;
        open_start_index <= prev_idx;
      end
    end
  end

  // Store the ping distance at this sample's index
  always_ff @(posedge clk) begin
    if (accept) begin
      ping_mem[sample_index] <= ping_distance;
    end
  end

  // Read the midpoint ping distance; hold it while the pipeline stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      ping_rd <= ping_mem[mid_addr];
    end
  end

  // Launch the beat into the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side <= '0;
    end else if (adv) begin
      s1_side.valid     <= accept;
      s1_side.close     <= do_close;
      s1_side.last      <= last;
      s1_side.mid_angle <= ang_sum[8:1];
      s1_side.ping_cm   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_h_raw    <= h_raw;
      s1_fwd      <= (mid_addr == sample_index);
      s1_fwd_ping <= ping_distance;
    end
  end

  // Forward the ping written in the same cycle as the midpoint read
  always_comb begin
    chord_side_in         = s1_side;
    chord_side_in.ping_cm = s1_fwd ? s1_fwd_ping : ping_rd;
  end

  ssof_chord u_chord (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .side_in   (chord_side_in),
    .h_raw_in  (s1_h_raw),
    .side_out  (fin_side),
    .width_out (fin_width)
  );

  // Keep the narrowest object; ties keep the earlier one
  assign better          = fin_side.valid && fin_side.close && (fin_width < best_width);
  assign best_width_next = better ? fin_width : best_width;
  assign best_angle_next = better ? fin_side.mid_angle : best_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_width <= ssof_pkg::NO_OBJECT;
      best_angle <= ssof_pkg::NO_OBJECT;
    end else if (adv && fin_side.valid) begin
      if (fin_side.last) begin
        best_width <= ssof_pkg::NO_OBJECT;
        best_angle <= ssof_pkg::NO_OBJECT;
      end else begin
        best_width <= best_width_next;
        best_angle <= best_angle_next;
      end
    end
  end

  // Result beat: load the output register, or park in the spare when it is busy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else if (held_valid) begin
      if (out_ready) begin
        held_valid <= 1'b0;
      end
    end else if (result_due) begin
      if (out_valid && !out_ready) begin
        held_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (held_valid) begin
      if (out_ready) begin
        smallest_angle <= held_angle;
      end
    end else if (result_due) begin
      if (out_valid && !out_ready) begin
        held_angle <= best_angle_next;
      end else begin
        smallest_angle <= best_angle_next;
      end
    end
  end

  // The input side holds back only behind a full spare and a further result
  a_ready_only_behind_result: assert property (
    @(posedge clk) disable iff (rst)
    !in_ready |-> (held_valid && fin_side.valid && fin_side.last)
  ) else $error("input stalled without a pending result");

  // A parked result always sits behind a valid output beat
  a_spare_behind_output: assert property (
    @(posedge clk) disable iff (rst)
    held_valid |-> out_valid
  ) else $error("spare result held with an empty output");

  // An end-of-sweep beat restarts the sweep tracking
  a_last_restarts_sweep: assert property (
    @(posedge clk) disable iff (rst)
    (accept && last) |=> (!have_prev && !in_object && sample_index == '0)
  ) else $error("sweep state not cleared after last beat");

  // An empty best width always goes with the no-object angle
  a_best_pair: assert property (
    @(posedge clk) disable iff (rst)
    (best_width == ssof_pkg::NO_OBJECT) |-> (best_angle == ssof_pkg::NO_OBJECT)
  ) else $error("best angle kept without a best width");

endmodule

`default_nettype wire
